// ----- src/frame_time_window_stats_macros.svh -----
// Assertion macros used by the checker file of the frame time window stats block.
`ifndef FRAME_TIME_WINDOW_STATS_MACROS_SVH
`define FRAME_TIME_WINDOW_STATS_MACROS_SVH

// Property checked at every clock edge outside reset
`define FTWS_ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every clock edge, reset included
`define FTWS_ASSERT_ALL(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/ftws_pkg.sv -----
// Package: shared constants and types of the frame time window stats block.
`timescale 1ns / 1ps
package ftws_pkg;

  localparam int DATA_W          = 64;
  localparam int STEP_W          = $clog2(DATA_W);
  localparam int WINDOW_SIZE_DEF = 32;

  // Percentile fractions
  localparam int PCT_A   = 95;
  localparam int PCT_B   = 99;
  localparam int PCT_DEN = 100;

  // x / 100 == (x * RECIP_100) >> RECIP_SHIFT, exact for x below 2^15
  localparam int RECIP_100   = 20972;
  localparam int RECIP_W     = 15;
  localparam int RECIP_SHIFT = 21;

  typedef enum logic [1:0] {
    ALU_ADD = 2'b01,
    ALU_SUB = 2'b10
  } alu_op_t;

  // carry: carry out on add, borrow on subtract
  typedef struct packed {
    logic carry;
    logic zero;
  } alu_flags_t;

endpackage

// ----- src/ftws_alu.sv -----
// Shared 64-bit add/subtract unit with carry and zero flags.
`timescale 1ns / 1ps
module ftws_alu (
  input  ftws_pkg::alu_op_t            op,
  input  logic [ftws_pkg::DATA_W-1:0]  a,
  input  logic [ftws_pkg::DATA_W-1:0]  b,
  output logic [ftws_pkg::DATA_W-1:0]  res,
  output ftws_pkg::alu_flags_t         flags
);
  import ftws_pkg::*;

  logic [DATA_W:0] full;

  // One adder serves sum, divide step and compare
  always_comb begin
    unique case (op)
      ALU_ADD: full = {1'b0, a} + {1'b0, b};
      ALU_SUB: full = {1'b0, a} - {1'b0, b};
      default: full = '0;
    endcase
    res         = full[DATA_W-1:0];
    flags.carry = full[DATA_W];
    flags.zero  = (full[DATA_W-1:0] == '0);
  end

endmodule

// ----- src/frame_time_window_stats.sv -----
// Top level: sliding-window mean and 95th/99th percentile of frame durations.
//
//   channel   direction  handshake                ports
//   ------------------------------------------------------------------------------
//   sample    in         start & !busy            frame_dur
//   result    out        done, one cycle, no hold last_dur mean_dur p95_dur p99_dur
//
// Each sample is worked through by the single ring read port and the shared adder:
//   a summing walk, a one-bit-per-cycle restoring divide, then one window scan per
//   candidate, of which 1 to n are examined (n = window fill after the write).
// Reset (rst, synchronous) empties the window; ring contents need no clearing.
// busy stays high from the accepting edge through the done beat; the receiver
//   cannot stall, so the result beat is taken in the cycle it is shown.
`timescale 1ns / 1ps
module frame_time_window_stats #(
  parameter int WINDOW_SIZE = ftws_pkg::WINDOW_SIZE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ftws_pkg::DATA_W-1:0]  frame_dur,
  output logic                         busy,
  output logic                         done,
  output logic [ftws_pkg::DATA_W-1:0]  last_dur,
  output logic [ftws_pkg::DATA_W-1:0]  mean_dur,
  output logic [ftws_pkg::DATA_W-1:0]  p95_dur,
  output logic [ftws_pkg::DATA_W-1:0]  p99_dur
);
  import ftws_pkg::*;

  localparam int AW     = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int CW     = $clog2(WINDOW_SIZE + 1);
  localparam int NUM_W  = CW + 7;
  localparam int PROD_W = NUM_W + RECIP_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SUM   = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_CAND  = 7'b0001000,
    S_CLOAD = 7'b0010000,
    S_SCAN  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic                accept;
  logic [AW-1:0]       write_slot;
  logic [CW-1:0]       fill_count;
  logic [CW-1:0]       idx;
  logic [CW-1:0]       cand_idx;
  logic [STEP_W-1:0]   step;
  logic                rd_en;
  logic                rd_vld;
  logic [AW-1:0]       rd_addr;
  logic [DATA_W-1:0]   rd_data;
  logic [DATA_W-1:0]   ring [WINDOW_SIZE];
  logic [DATA_W-1:0]   acc;
  logic [CW-1:0]       rem;
  logic [CW:0]         rem_sh;
  logic                div_ge;
  logic [DATA_W-1:0]   cand;
  logic [CW-1:0]       cnt_lt, cnt_le;
  logic [CW-1:0]       lt_f, le_f;
  logic                found95, found99;
  logic                hit95, hit99;
  logic                scan_end, last_cand;
  logic [NUM_W-1:0]    num95, num99;
  logic [PROD_W-1:0]   prod95, prod99;
  logic [CW-1:0]       rank95, rank99;

  alu_op_t             alu_op;
  logic [DATA_W-1:0]   alu_a, alu_b, alu_res;
  alu_flags_t          alu_flags;

  ftws_alu u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .res   (alu_res),
    .flags (alu_flags)
  );

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign done   = (state == S_DONE);

  // Divide step and scan compare decode
  assign rem_sh    = {rem, acc[DATA_W-1]};
  assign div_ge    = !alu_flags.carry;
  assign lt_f      = cnt_lt + CW'(alu_flags.carry);
  assign le_f      = cnt_le + CW'(alu_flags.carry | alu_flags.zero);
  assign hit95     = !found95 && (lt_f < rank95) && (rank95 <= le_f);
  assign hit99     = !found99 && (lt_f < rank99) && (rank99 <= le_f);
  assign scan_end  = (idx == fill_count) && rd_vld;
  assign last_cand = (cand_idx == CW'(fill_count - 1'b1));

  // Sequencer and shared unit operand select
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = idx[AW-1:0];
    alu_op     = ALU_ADD;
    alu_a      = acc;
    alu_b      = rd_data;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_SUM;
      end
      S_SUM: begin
        rd_en = (idx != fill_count);
        if (scan_end) state_next = S_DIV;
      end
      S_DIV: begin
        alu_op = ALU_SUB;
        alu_a  = DATA_W'(rem_sh);
        alu_b  = DATA_W'(fill_count);
        if (step == STEP_W'(DATA_W - 1)) state_next = S_CAND;
      end
      S_CAND: begin
        rd_en      = 1'b1;
        rd_addr    = cand_idx[AW-1:0];
        state_next = S_CLOAD;
      end
      S_CLOAD: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        rd_en  = (idx != fill_count);
        alu_op = ALU_SUB;
        alu_a  = rd_data;
        alu_b  = cand;
        if (scan_end) begin
          if (((found95 || hit95) && (found99 || hit99)) || last_cand) begin
            state_next = S_DONE;
          end else begin
            state_next = S_CAND;
          end
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sample ring: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept) ring[write_slot] <= frame_dur;
    if (rd_en) rd_data <= ring[rd_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      write_slot <= '0;
      fill_count <= '0;
      idx        <= '0;
      cand_idx   <= '0;
      step       <= '0;
      rd_vld     <= 1'b0;
      found95    <= 1'b0;
      found99    <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;
      if (rd_en && (state == S_SUM || state == S_SCAN)) idx <= idx + 1'b1;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            write_slot <= (write_slot == AW'(WINDOW_SIZE - 1)) ? '0 : write_slot + 1'b1;
            if (fill_count != CW'(WINDOW_SIZE)) fill_count <= fill_count + 1'b1;
            idx <= '0;
          end
        end
        S_SUM: begin
          step <= '0;
        end
        S_DIV: begin
          step     <= step + 1'b1;
          cand_idx <= '0;
          found95  <= 1'b0;
          found99  <= 1'b0;
        end
        S_CLOAD: begin
          idx <= '0;
        end
        S_SCAN: begin
          if (scan_end) begin
            found95  <= found95 || hit95;
            found99  <= found99 || hit99;
            cand_idx <= cand_idx + 1'b1;
          end
        end
        S_CAND, S_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Rank targets follow the fill count through two registered steps
  assign prod95 = PROD_W'(num95) * PROD_W'(RECIP_100);
  assign prod99 = PROD_W'(num99) * PROD_W'(RECIP_100);

  always_ff @(posedge clk) begin
    num95  <= NUM_W'(32'(fill_count) * PCT_A + PCT_DEN - 1);
    num99  <= NUM_W'(32'(fill_count) * PCT_B + PCT_DEN - 1);
    rank95 <= CW'(prod95 >> RECIP_SHIFT);
    rank99 <= CW'(prod99 >> RECIP_SHIFT);
  end

  // Datapath: sum, restoring divide, candidate counts, results
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          last_dur <= frame_dur;
          acc      <= '0;
        end
      end
      S_SUM: begin
        if (rd_vld) acc <= alu_res;
        rem <= '0;
      end
      S_DIV: begin
        rem <= div_ge ? alu_res[CW-1:0] : rem_sh[CW-1:0];
        acc <= {acc[DATA_W-2:0], div_ge};
        if (step == STEP_W'(DATA_W - 1)) mean_dur <= {acc[DATA_W-2:0], div_ge};
      end
      S_CLOAD: begin
        cand   <= rd_data;
        cnt_lt <= '0;
        cnt_le <= '0;
      end
      S_SCAN: begin
        if (rd_vld) begin
          cnt_lt <= lt_f;
          cnt_le <= le_f;
        end
        if (scan_end && hit95) p95_dur <= cand;
        if (scan_end && hit99) p99_dur <= cand;
      end
      S_CAND, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- src/ftws_check.sv -----
// Port-level checker for the frame time window stats block, with its bind.
`timescale 1ns / 1ps
`include "frame_time_window_stats_macros.svh"
module ftws_check (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // A beat taken makes the block busy from the accepting edge
  `FTWS_ASSERT_RST(a_accept_busy, clk, rst, (start && !busy) |=> busy, "busy not raised after accept")

  // No result in the cycle right after an accept
  `FTWS_ASSERT_RST(a_accept_no_done, clk, rst, (start && !busy) |=> !done, "result too early")

  // Result beat ends the busy span
  `FTWS_ASSERT_RST(a_done_idle, clk, rst, done |=> !busy, "busy held after result")

  // busy only rises from a start request
  `FTWS_ASSERT_RST(a_busy_cause, clk, rst, $rose(busy) |-> $past(start), "busy rose without start")

  // Reset leaves the block idle with no result
  `FTWS_ASSERT_ALL(a_reset_idle, clk, rst |=> (!busy && !done), "not idle after reset")

endmodule

bind frame_time_window_stats ftws_check u_ftws_check (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
